// ===== hdl/cpbr_pkg.sv =====
// Package for the phonebook reply line parser.
// Holds the payload types, the phase and code enums, and the character constants.
// Used by the parser core, the result queue and the top level; depends on nothing.
package cpbr_pkg;

	localparam int PREFIX_LEN = 6;
	localparam int DEC_BASE   = 10;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [15:0] IDX_SAT     = 16'hFFFF;
	localparam logic [15:0] TYP_SAT     = 16'd32768;
	localparam logic [15:0] TYP_POS_MAX = 16'd32767;

	typedef enum logic [1:0] {
		KIND_NUMBER = 2'd0,
		KIND_NAME   = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_PREFIX = 3'd1,
		ST_INDEX  = 3'd2,
		ST_NUMBER = 3'd3,
		ST_TYPE   = 3'd4,
		ST_NAME   = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		PH_PREFIX   = 4'd0,
		PH_IDX_LEAD = 4'd1,
		PH_IDX_NUM  = 4'd2,
		PH_IDX_SEP  = 4'd3,
		PH_NUM_Q    = 4'd4,
		PH_TYP_SEP  = 4'd5,
		PH_TYP_LEAD = 4'd6,
		PH_TYP_NUM  = 4'd7,
		PH_TYP_SEP2 = 4'd8,
		PH_NAME_Q   = 4'd9,
		PH_DONE     = 4'd10,
		PH_HALT     = 4'd11
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       line_end;
	} in_item_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         char_out;
		logic [15:0]        entry_index;
		logic signed [15:0] entry_type;
		status_t            status;
	} result_t;

	// Up to two results leave the parser per byte: a character, then a line status.
	typedef struct packed {
		logic    char_valid;
		logic    stat_valid;
		result_t char_res;
		result_t stat_res;
	} push_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	// Characters of the literal "+CPBR:" by position.
	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0:    c = CH_PLUS;
			3'd1:    c = 8'h43;
			3'd2:    c = 8'h50;
			3'd3:    c = 8'h42;
			3'd4:    c = 8'h52;
			3'd5:    c = 8'h3A;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/cpbr_stream_if.sv =====
// Valid/ready stream interface used for the byte input and the result output.
// The payload type is a parameter; the payload structs come from cpbr_pkg.
interface cpbr_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cpbr_parse_core.sv =====
// Parser state machine: one byte per step, state register plus next-state logic.
// Produces up to two results per byte as a cpbr_pkg::push_t; depends on cpbr_pkg.
module cpbr_parse_core #(
	parameter int NUMBER_MAX = 31,
	parameter int NAME_MAX   = 31
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     in_byte,
	input  logic           line_end,
	output cpbr_pkg::push_t push
);
	import cpbr_pkg::*;

	localparam int FieldMax = (NUMBER_MAX > NAME_MAX) ? NUMBER_MAX : NAME_MAX;
	localparam int FcW      = $clog2(FieldMax + 1);

	typedef struct packed {
		phase_t       phase;
		logic [2:0]   pos;
		logic [15:0]  idx;
		logic [15:0]  typ;
		logic         neg;
		logic         ds;
		logic [FcW-1:0] fc;
		status_t      err;
	} pstate_t;

	pstate_t st_q;
	pstate_t st_next;

	function automatic logic [15:0] idx_acc(input logic [15:0] a, input logic [3:0] d);
		logic [19:0] t;
		t = 20'(a) * 20'(DEC_BASE) + 20'(d);
		return (t > 20'(IDX_SAT)) ? IDX_SAT : t[15:0];
	endfunction

	function automatic logic [15:0] typ_acc(input logic [15:0] a, input logic [3:0] d);
		logic [19:0] t;
		t = 20'(a) * 20'(DEC_BASE) + 20'(d);
		return (t > 20'(TYP_SAT)) ? TYP_SAT : t[15:0];
	endfunction

	function automatic pstate_t fail(input pstate_t s, input status_t code);
		pstate_t r;
		r = s;
		if (r.err == ST_OK) begin
			r.err = code;
		end
		r.phase = PH_HALT;
		return r;
	endfunction

	function automatic pstate_t finish_index(input pstate_t s);
		pstate_t r;
		r = s;
		if (r.neg) begin
			r.idx = 16'(~r.idx + 16'd1);
		end
		r.neg = 1'b0;
		r.ds  = 1'b0;
		return r;
	endfunction

	function automatic pstate_t finish_type(input pstate_t s);
		pstate_t r;
		r = s;
		if (r.neg) begin
			r.typ = 16'(~r.typ + 16'd1);
		end else if (r.typ > TYP_POS_MAX) begin
			r.typ = TYP_POS_MAX;
		end
		r.neg = 1'b0;
		r.ds  = 1'b0;
		return r;
	endfunction

	// Separator before a quoted field: spaces and commas skipped, a quote opens it.
	function automatic pstate_t sep_step(input pstate_t s, input logic [7:0] b,
			input logic is_name);
		pstate_t r;
		r = s;
		if (b == CH_QUOTE) begin
			r.fc    = '0;
			r.phase = is_name ? PH_NAME_Q : PH_NUM_Q;
		end else if ((b != CH_SPACE) && (b != CH_COMMA)) begin
			r = fail(r, is_name ? ST_NAME : ST_NUMBER);
		end
		return r;
	endfunction

	// Leading part of a decimal field: whitespace, an optional sign, first digit.
	function automatic pstate_t lead_step(input pstate_t s, input logic [7:0] b,
			input logic is_type);
		pstate_t r;
		r = s;
		if (b == CH_PLUS || b == CH_MINUS) begin
			r.neg   = (b == CH_MINUS);
			r.ds    = 1'b0;
			r.phase = is_type ? PH_TYP_NUM : PH_IDX_NUM;
		end else if (is_digit(b)) begin
			r.neg = 1'b0;
			r.ds  = 1'b1;
			if (is_type) begin
				r.typ = typ_acc(r.typ, b[3:0]);
			end else begin
				r.idx = idx_acc(r.idx, b[3:0]);
			end
			r.phase = is_type ? PH_TYP_NUM : PH_IDX_NUM;
		end else if (!is_ws(b)) begin
			r = fail(r, is_type ? ST_TYPE : ST_INDEX);
		end
		return r;
	endfunction

	// What the line still needed when it ends early becomes the error.
	function automatic pstate_t end_parse(input pstate_t s);
		pstate_t r;
		r = s;
		unique case (r.phase)
			PH_PREFIX:   r = fail(r, ST_PREFIX);
			PH_IDX_LEAD: r = fail(r, ST_INDEX);
			PH_IDX_NUM: begin
				if (!r.ds) begin
					r = fail(r, ST_INDEX);
				end else begin
					r = fail(finish_index(r), ST_NUMBER);
				end
			end
			PH_IDX_SEP, PH_NUM_Q:    r = fail(r, ST_NUMBER);
			PH_TYP_SEP, PH_TYP_LEAD: r = fail(r, ST_TYPE);
			PH_TYP_NUM: begin
				if (!r.ds) begin
					r = fail(r, ST_TYPE);
				end else begin
					r = fail(finish_type(r), ST_NAME);
				end
			end
			PH_TYP_SEP2, PH_NAME_Q:  r = fail(r, ST_NAME);
			default:                 r.phase = PH_HALT;
		endcase
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			st_q <= st_next;
		end
	end

	always_comb begin
		pstate_t s;
		s    = st_q;
		push = '0;
		push.char_res.char_out = in_byte;
		push.char_res.kind     = KIND_NUMBER;
		push.stat_res.kind     = KIND_STATUS;

		if (s.phase != PH_HALT) begin
			if (in_byte == CH_NUL) begin
				s = end_parse(s);
			end else begin
				unique case (s.phase)
					PH_PREFIX: begin
						if (s.pos < 3'(PREFIX_LEN) && in_byte == prefix_char(s.pos)) begin
							s.pos = s.pos + 3'd1;
							if (s.pos == 3'(PREFIX_LEN)) begin
								s.phase = PH_IDX_LEAD;
							end
						end else begin
							s = fail(s, ST_PREFIX);
						end
					end
					PH_IDX_LEAD: s = lead_step(s, in_byte, 1'b0);
					PH_TYP_LEAD: s = lead_step(s, in_byte, 1'b1);
					PH_IDX_NUM: begin
						if (is_digit(in_byte)) begin
							s.idx = idx_acc(s.idx, in_byte[3:0]);
							s.ds  = 1'b1;
						end else if (!s.ds) begin
							s = fail(s, ST_INDEX);
						end else begin
							// The byte that ends the digits is already a separator byte.
							s       = finish_index(s);
							s.phase = PH_IDX_SEP;
							s       = sep_step(s, in_byte, 1'b0);
						end
					end
					PH_IDX_SEP:  s = sep_step(s, in_byte, 1'b0);
					PH_TYP_SEP2: s = sep_step(s, in_byte, 1'b1);
					PH_NUM_Q, PH_NAME_Q: begin
						if (in_byte == CH_QUOTE) begin
							s.phase = (s.phase == PH_NUM_Q) ? PH_TYP_SEP : PH_DONE;
						end else if (s.fc < ((s.phase == PH_NUM_Q) ? FcW'(NUMBER_MAX)
								: FcW'(NAME_MAX))) begin
							s.fc = s.fc + FcW'(1);
							push.char_valid    = 1'b1;
							push.char_res.kind = (s.phase == PH_NUM_Q) ? KIND_NUMBER
								: KIND_NAME;
						end
					end
					PH_TYP_SEP: begin
						if (in_byte != CH_SPACE && in_byte != CH_COMMA) begin
							s.phase = PH_TYP_LEAD;
							s = lead_step(s, in_byte, 1'b1);
						end
					end
					PH_TYP_NUM: begin
						if (is_digit(in_byte)) begin
							s.typ = typ_acc(s.typ, in_byte[3:0]);
							s.ds  = 1'b1;
						end else if (!s.ds) begin
							s = fail(s, ST_TYPE);
						end else begin
							s       = finish_type(s);
							s.phase = PH_TYP_SEP2;
							s       = sep_step(s, in_byte, 1'b1);
						end
					end
					default: ;
				endcase
			end
		end

		if (line_end) begin
			if (s.phase != PH_HALT) begin
				s = end_parse(s);
			end
			push.stat_valid           = 1'b1;
			push.stat_res.entry_index = s.idx;
			push.stat_res.entry_type  = s.typ;
			push.stat_res.status      = s.err;
			s = '0;
		end
		st_next = s;
	end

	a_line_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && line_end |=> st_q.phase == PH_PREFIX && st_q.err == ST_OK)
		else $error("parser state not cleared after line end");

	a_prefix_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.pos <= 3'(PREFIX_LEN))
		else $error("prefix position beyond literal length");

endmodule

// ===== hdl/cpbr_result_fifo.sv =====
// Four-entry result queue that accepts up to two results per cycle.
// Drives the output stream; depends on cpbr_pkg and cpbr_stream_if.
module cpbr_result_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_en,
	input  cpbr_pkg::push_t push,
	output logic            room,
	cpbr_stream_if.source   res
);
	import cpbr_pkg::*;

	localparam int Depth = 4;
	localparam int PtrW  = $clog2(Depth);

	result_t         mem_q [Depth];
	logic [PtrW-1:0] head_q;
	logic [PtrW-1:0] tail_q;
	logic [PtrW:0]   count_q;
	logic            pop;
	logic            wr_char;
	logic            wr_stat;
	logic [PtrW-1:0] stat_ptr;
	logic [PtrW:0]   n_push;

	assign pop      = res.valid && res.ready;
	assign wr_char  = push_en && push.char_valid;
	assign wr_stat  = push_en && push.stat_valid;
	assign stat_ptr = wr_char ? tail_q + PtrW'(1) : tail_q;
	assign n_push   = (PtrW + 1)'(wr_char) + (PtrW + 1)'(wr_stat);
	// Two free slots are needed because one byte may cause two results.
	assign room     = count_q <= (PtrW + 1)'(Depth - 2);

	assign res.valid = count_q != '0;
	assign res.data  = mem_q[head_q];

	always_ff @(posedge clk) begin
		if (wr_char) begin
			mem_q[tail_q] <= push.char_res;
		end
		if (wr_stat) begin
			mem_q[stat_ptr] <= push.stat_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + PtrW'(1);
			end
			tail_q  <= tail_q + n_push[PtrW-1:0];
			count_q <= count_q + n_push - (PtrW + 1)'(pop);
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PtrW + 1)'(Depth))
		else $error("result queue overfilled");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_char || wr_stat) |-> $past(1'b1) && count_q <= (PtrW + 1)'(Depth - 2))
		else $error("result pushed without two free slots");

endmodule

// ===== hdl/phonebook_entry_line_parser_unit.sv =====
// Phonebook reply line parser, top level: input stage, parser, result queue.
// Order: a byte is registered in the input stage, then parsed into the result queue,
// which offers its results; a line status behind a character comes after it.
// Throughput: one byte per cycle while the queue has room; a byte that yields a
// character and a line status queues two results; one per cycle leaves when taken.
// Reset: arst_n clears the input stage, the parser state and the queue at once.
// Depends on cpbr_pkg, cpbr_stream_if, cpbr_parse_core and cpbr_result_fifo.
module phonebook_entry_line_parser_unit #(
	parameter int NUMBER_MAX = 31,
	parameter int NAME_MAX   = 31
) (
	input  logic          clk,
	input  logic          arst_n,
	cpbr_stream_if.sink   char_stream,
	cpbr_stream_if.source result_stream
);
	import cpbr_pkg::*;

	// The input stage holds one byte. It moves into the parser when the result
	// queue has room for the two results that a single byte can cause, so a new
	// byte transfer is taken in the same cycle that the held byte is parsed.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       line_end_s1;
	logic       room;
	logic       advance;
	logic       take;
	push_t      push;

	assign advance           = valid_s1 && room;
	assign char_stream.ready = !valid_s1 || room;
	assign take              = char_stream.valid && char_stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload registers need no reset; they are qualified by valid_s1.
	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1     <= char_stream.data.in_byte;
			line_end_s1 <= char_stream.data.line_end;
		end
	end

	// The parser advances its state once per byte and emits a character
	// result for a quoted character and a line status when the line ends.
	cpbr_parse_core #(
		.NUMBER_MAX(NUMBER_MAX),
		.NAME_MAX  (NAME_MAX)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.in_byte (byte_s1),
		.line_end(line_end_s1),
		.push    (push)
	);

	// Results wait here until the downstream side takes them, so a stalled
	// output does not stop the input until the queue is nearly full.
	cpbr_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push_en(advance),
		.push   (push),
		.room   (room),
		.res    (result_stream)
	);

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1 && $stable(byte_s1) && $stable(line_end_s1))
		else $error("input stage lost a byte while the queue was full");

endmodule
